// ----- rtl/pcr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared constants, result type and header field map of the packet checksum
// reassembler.
// ----------------------------------------------------------------------------
package pcr_pkg;

	localparam int INDEX_BITS_DEF = 24;
	localparam int IDX_W          = 24;   // write_index, positions, lengths
	localparam int LEN_W          = 25;   // buffer length register
	localparam int FIELD_W        = 40;
	localparam int SUM_W          = 43;
	localparam int CNT_W          = 32;
	localparam int DATA_W         = 8;
	localparam int KIND_W         = 2;
	localparam int TDATA_OUT_W    = 72;

	localparam logic [LEN_W-1:0] MSG_LEN_RST = 25'd16777216;
	localparam logic [IDX_W-1:0] POS_MAX     = 24'hFFFFFF;
	localparam logic [32:0]      MOD_VAL     = 33'h0_FFFF_FFFF;

	// byte positions inside the header
	localparam logic [IDX_W-1:0] POS_FRAG_END = 24'd14;
	localparam logic [IDX_W-1:0] POS_TLEN_END = 24'd19;
	localparam logic [IDX_W-1:0] POS_FOLD     = 24'd20;
	localparam logic [IDX_W-1:0] POS_CSUM_END = 24'd23;
	localparam logic [IDX_W-1:0] HDR_LEN      = 24'd24;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

	// input action codes
	localparam logic ACT_BYTE   = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  write_index;
		logic [DATA_W-1:0] write_data;
		logic              accepted;
		logic [CNT_W-1:0]  accepted_count;
		logic              last;
	} result_t;

	// true when this position holds the last byte of one of the seven
	// summed header fields (5,5,1,1,3,2,3 bytes)
	function automatic logic field_end(input logic [IDX_W-1:0] pos);
		logic hit;
		case (pos)
			24'd4, 24'd9, 24'd10, 24'd11, 24'd14, 24'd16, 24'd19: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

// ----- rtl/packet_checksum_reassembler.sv -----
// ----------------------------------------------------------------------------
// packet_checksum_reassembler
// Checks the header checksum of each packet and turns payload bytes of good
// packets into message buffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one packet byte per beat (tuser = finish flag, tlast = last
//   byte of the packet). A finish beat ends the set of packets and reports
//   the count of accepted packets.
//   m_* carries results: message writes, one packet status per packet and a
//   set done per finish; tlast marks the final result of an input beat.
//   cfg_* writes the destination buffer length, between packets.
// Timing: the results of a beat are written into the output queue as the
//   beat is taken. Throughput is one input beat per cycle while s_tready
//   is high; a beat with two results sends them in turn on the single port.
// The results go through a four-entry queue; s_tready is high while two
//   entries are free, so a stalled receiver stops the input once three
//   results are waiting; beats without results pass until then.
// Reset clears the packet state, the count and the queue, and sets the
//   buffer length to 16777216.
// ----------------------------------------------------------------------------
module packet_checksum_reassembler #(
	parameter int INDEX_BITS = pcr_pkg::INDEX_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pcr_pkg::LEN_W-1:0]             cfg_data,   // buffer length
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [7:0]                            s_tdata,    // packet_byte
	input  logic [0:0]                            s_tuser,    // action
	input  logic                                  s_tlast,    // end_of_packet
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// write_index[23:0], write_data[31:24], accepted[32],
	// accepted_count[64:33], zero fill
	output logic [pcr_pkg::TDATA_OUT_W-1:0]       m_tdata,
	output logic [pcr_pkg::KIND_W-1:0]            m_tuser,    // kind
	output logic                                  m_tlast     // last
);

	localparam int IW = pcr_pkg::IDX_W;
	localparam int LW = pcr_pkg::LEN_W;
	localparam logic [LW-1:0] LEN_CAP = LW'(1) << INDEX_BITS;

	logic [LW-1:0]                 msg_len_q;
	logic [IW-1:0]                 pos_q;
	logic [pcr_pkg::FIELD_W-1:0]   field_q;
	logic [pcr_pkg::SUM_W-1:0]     hsum_q;
	logic [IW-1:0]                 frag_q;
	logic [IW-1:0]                 tlen_q;
	logic                          pkt_ok_q;
	logic [INDEX_BITS-1:0]         nwi_q;
	logic [INDEX_BITS-1:0]         right_q;
	logic [pcr_pkg::CNT_W-1:0]     count_q;

	pcr_pkg::result_t              queue_q [pcr_pkg::QDEPTH];
	logic [pcr_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [pcr_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [pcr_pkg::QCNT_W-1:0]    qcnt_q;

	logic                          in_fire;
	logic                          out_fire;
	logic                          is_finish;
	logic [LW-1:0]                 eff_len;
	logic [pcr_pkg::FIELD_W-1:0]   field_next;
	logic                          in_hdr;
	logic                          do_write;
	logic                          hdr_pass;
	logic                          pkt_ok_next;
	logic [pcr_pkg::CNT_W-1:0]     count_next;
	logic [32:0]                   fold_sum;
	logic [32:0]                   fold_res;
	logic [IW-1:0]                 term_index;
	logic                          res_a_vld;
	logic                          res_b_vld;
	pcr_pkg::result_t              res_a;
	pcr_pkg::result_t              res_b;
	pcr_pkg::result_t              push_first;
	pcr_pkg::result_t              head;
	logic [1:0]                    n_push;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid & s_tready;
	assign out_fire  = m_tvalid & m_tready;
	assign s_tready  = qcnt_q <= pcr_pkg::QCNT_W'(pcr_pkg::QDEPTH - 2);
	assign is_finish = s_tuser[0] == pcr_pkg::ACT_FINISH;

	assign eff_len    = (msg_len_q > LEN_CAP) ? LEN_CAP : msg_len_q;
	assign field_next = {field_q[pcr_pkg::FIELD_W-9:0], s_tdata};
	assign in_hdr     = pos_q < pcr_pkg::HDR_LEN;

	// checksum and offset check on the last header byte
	assign hdr_pass = (pos_q == pcr_pkg::POS_CSUM_END)
		&& ({11'd0, field_next[31:0]} == hsum_q)
		&& ((LW+1)'(frag_q) + (LW+1)'(2) <= (LW+1)'(eff_len));

	assign do_write = !in_hdr && pkt_ok_q && (pos_q < tlen_q)
		&& ((LW)'(nwi_q) + LW'(1) < eff_len);

	assign pkt_ok_next = pkt_ok_q | hdr_pass;
	assign count_next  = hdr_pass ? count_q + 1'b1 : count_q;

	// fold of the raw header sum mod 2^32-1
	assign fold_sum = {1'b0, hsum_q[31:0]} + 33'(hsum_q[pcr_pkg::SUM_W-1:32]);
	assign fold_res = (fold_sum >= pcr_pkg::MOD_VAL) ? fold_sum - pcr_pkg::MOD_VAL
		: fold_sum;

	assign term_index = IW'(right_q) + IW'(1);

	always_comb begin
		res_a = '0;
		res_b = '0;
		if (is_finish) begin
			res_a_vld                  = right_q != '0;
			res_a.kind                 = pcr_pkg::KIND_WRITE;
			res_a.write_index          = term_index;
			res_b_vld                  = 1'b1;
			res_b.kind                 = pcr_pkg::KIND_DONE;
			res_b.accepted_count       = count_q;
		end else begin
			res_a_vld                  = do_write;
			res_a.kind                 = pcr_pkg::KIND_WRITE;
			res_a.write_index          = IW'(nwi_q);
			res_a.write_data           = s_tdata;
			res_b_vld                  = s_tlast;
			res_b.kind                 = pcr_pkg::KIND_STATUS;
			res_b.accepted             = pkt_ok_next;
			res_b.accepted_count       = count_next;
		end
		res_b.last = 1'b1;
		push_first = res_a_vld ? res_a : res_b;
		push_first.last = !(res_a_vld && res_b_vld);
		n_push = {1'b0, res_a_vld} + {1'b0, res_b_vld};
		if (!in_fire)
			n_push = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= pcr_pkg::MSG_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			msg_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			field_q  <= '0;
			hsum_q   <= '0;
			frag_q   <= '0;
			tlen_q   <= '0;
			pkt_ok_q <= 1'b0;
			nwi_q    <= '0;
			right_q  <= '0;
			count_q  <= '0;
		end else if (in_fire) begin
			if (is_finish || s_tlast) begin
				pos_q    <= '0;
				field_q  <= '0;
				hsum_q   <= '0;
				frag_q   <= '0;
				tlen_q   <= '0;
				pkt_ok_q <= 1'b0;
			end else begin
				if (pos_q != pcr_pkg::POS_MAX)
					pos_q <= pos_q + 1'b1;
				if (in_hdr) begin
					if (pcr_pkg::field_end(pos_q) || pos_q == pcr_pkg::POS_CSUM_END)
						field_q <= '0;
					else
						field_q <= field_next;
				end
				if (pcr_pkg::field_end(pos_q))
					hsum_q <= hsum_q + pcr_pkg::SUM_W'(field_next);
				if (pos_q == pcr_pkg::POS_FOLD)
					hsum_q <= pcr_pkg::SUM_W'(fold_res);
				if (pos_q == pcr_pkg::POS_FRAG_END)
					frag_q <= field_next[IW-1:0];
				if (pos_q == pcr_pkg::POS_TLEN_END)
					tlen_q <= field_next[IW-1:0];
				pkt_ok_q <= pkt_ok_next;
			end
			if (is_finish) begin
				nwi_q   <= '0;
				right_q <= '0;
				count_q <= '0;
			end else begin
				count_q <= count_next;
				if (hdr_pass)
					nwi_q <= frag_q[INDEX_BITS-1:0];
				if (do_write) begin
					nwi_q <= nwi_q + 1'b1;
					if (nwi_q > right_q)
						right_q <= nwi_q;
				end
			end
		end
	end

	// result queue, up to two pushes and one pop per cycle
	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			queue_q[wr_ptr_q] <= push_first;
		if (n_push == 2'd2)
			queue_q[wr_ptr_q + 1'b1] <= res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			qcnt_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + pcr_pkg::QPTR_W'(n_push);
			if (out_fire)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			qcnt_q <= qcnt_q + pcr_pkg::QCNT_W'(n_push)
				- pcr_pkg::QCNT_W'(out_fire);
		end
	end

	assign head     = queue_q[rd_ptr_q];
	assign m_tvalid = qcnt_q != '0;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {7'd0, head.accepted_count, head.accepted, head.write_data,
		head.write_index};

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet checksum reassembler. Builds packets
// with computed or corrupted header checksums, streams them byte by byte
// with random gaps, and checks every message write, packet status and set
// done result against a cycle-free copy of the header and payload logic.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [24:0] IDX_SPAN    = 25'h1000000;   // 2^24 index space
	localparam logic [23:0] FRAG_LAST   = 24'd14;
	localparam logic [23:0] TLEN_LAST   = 24'd19;
	localparam logic [23:0] CSUM_LAST   = 24'd23;
	localparam logic [23:0] HDR_BYTES   = 24'd24;
	localparam logic [23:0] POS_SAT     = 24'hFFFFFF;
	localparam logic [42:0] FOLD_MOD    = 43'h0FFFFFFFF;
	localparam int          RAND_BEATS  = 1250;
	localparam int          QUIET_AFTER = 1050;

	typedef enum logic [1:0] {ST_FINISH, ST_PACKET, ST_CONFIG} step_e;
	typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;
	typedef enum logic [1:0] {SUM_GOOD, SUM_BAD, SUM_ONES} csum_e;

	typedef struct packed {
		step_e       step;
		fill_e       fill;
		csum_e       csum;
		logic [23:0] frag;
		logic [23:0] tlen;
		int          nbytes;
		bit          cut;
		logic [24:0] len_val;
		int          want_acc;   // -1: take it from the tracker
		longint      want_cnt;   // -1: take it from the tracker
	} plan_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [pcr_pkg::LEN_W-1:0]           cfg_data;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [7:0]                          s_tdata;    // packet_byte
	logic [0:0]                          s_tuser;    // action
	logic                                s_tlast;    // end_of_packet
	logic                                m_tvalid;
	logic                                m_tready;
	// write_index[23:0], write_data[31:24], accepted[32], accepted_count[64:33]
	logic [pcr_pkg::TDATA_OUT_W-1:0]     m_tdata;
	logic [pcr_pkg::KIND_W-1:0]          m_tuser;    // kind
	logic                                m_tlast;

	// reassembly state mirrored on the bench side
	logic [24:0] buf_len;
	logic [23:0] pos_cnt;
	logic [39:0] acc_field;
	logic [42:0] hdr_total;
	logic [23:0] frag_off;
	logic [23:0] tot_len;
	logic        pkt_good;
	logic [23:0] wr_ptr;
	logic [23:0] max_idx;
	logic [31:0] good_pkts;

	pcr_pkg::result_t out_due[$];
	plan_row_t        plan[$];

	int  errs;
	int  beats_sent;
	bit  quiet;
	bit  tx_choppy;
	int  rx_hold;
	int  rx_span;
	bit  rx_choppy;

	packet_checksum_reassembler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic pcr_pkg::result_t mk_result(logic [1:0] k, logic [23:0] idx,
			logic [7:0] d, logic a, logic [31:0] c);
		pcr_pkg::result_t r;
		r.kind           = k;
		r.write_index    = idx;
		r.write_data     = d;
		r.accepted       = a;
		r.accepted_count = c;
		r.last           = 1'b0;
		return r;
	endfunction

	function automatic plan_row_t mk_row(step_e st, fill_e fl, csum_e cs, logic [23:0] frag,
			logic [23:0] tlen, int nbytes, bit cut, logic [24:0] len_val, int want_acc,
			longint want_cnt);
		plan_row_t p;
		p.step     = st;
		p.fill     = fl;
		p.csum     = cs;
		p.frag     = frag;
		p.tlen     = tlen;
		p.nbytes   = nbytes;
		p.cut      = cut;
		p.len_val  = len_val;
		p.want_acc = want_acc;
		p.want_cnt = want_cnt;
		return p;
	endfunction

	task automatic clear_pkt();
		pos_cnt   = '0;
		acc_field = '0;
		hdr_total = '0;
		frag_off  = '0;
		tot_len   = '0;
		pkt_good  = 1'b0;
	endtask

	// advance the mirrored state by one accepted beat and queue its results
	task automatic checksum_step(input logic act, input logic [7:0] b, input logic eop);
		int               due_cnt;
		logic [24:0]      eff;
		logic [31:0]      given;
		pcr_pkg::result_t r;
		due_cnt = out_due.size();
		eff = (buf_len > IDX_SPAN) ? IDX_SPAN : buf_len;
		if (act == pcr_pkg::ACT_FINISH) begin
			if (max_idx != 0)
				out_due.push_back(mk_result(pcr_pkg::KIND_WRITE, max_idx + 24'd1, 8'd0, 1'b0,
					32'd0));
			out_due.push_back(mk_result(pcr_pkg::KIND_DONE, 24'd0, 8'd0, 1'b0, good_pkts));
			good_pkts = '0;
			max_idx   = '0;
			wr_ptr    = '0;
			clear_pkt();
		end else begin
			if (pos_cnt < HDR_BYTES) begin
				acc_field = {acc_field[31:0], b};
				if (pos_cnt <= TLEN_LAST) begin
					case (pos_cnt)
						24'd4, 24'd9, 24'd10, 24'd11, 24'd14, 24'd16, 24'd19: begin
							hdr_total = hdr_total + {3'b000, acc_field};
							if (pos_cnt == FRAG_LAST)
								frag_off = acc_field[23:0];
							if (pos_cnt == TLEN_LAST) begin
								tot_len   = acc_field[23:0];
								hdr_total = hdr_total % FOLD_MOD;
							end
							acc_field = '0;
						end
						default: ;
					endcase
				end else if (pos_cnt == CSUM_LAST) begin
					given     = acc_field[31:0];
					acc_field = '0;
					if ({11'd0, given} == hdr_total && eff >= 25'd2 &&
							{1'b0, frag_off} <= eff - 25'd2) begin
						pkt_good  = 1'b1;
						good_pkts = good_pkts + 32'd1;
						wr_ptr    = frag_off;
					end
				end
			end else if (pkt_good && pos_cnt < tot_len && eff >= 25'd2 &&
					{1'b0, wr_ptr} < eff - 25'd1) begin
				out_due.push_back(mk_result(pcr_pkg::KIND_WRITE, wr_ptr, b, 1'b0, 32'd0));
				if (wr_ptr > max_idx)
					max_idx = wr_ptr;
				wr_ptr = wr_ptr + 24'd1;
			end
			if (pos_cnt != POS_SAT)
				pos_cnt = pos_cnt + 24'd1;
			if (eop) begin
				out_due.push_back(mk_result(pcr_pkg::KIND_STATUS, 24'd0, 8'd0, pkt_good,
					good_pkts));
				clear_pkt();
			end
		end
		if (out_due.size() > due_cnt) begin
			r = out_due.pop_back();
			r.last = 1'b1;
			out_due.push_back(r);
		end
	endtask

	task automatic send_beat(input logic act, input logic [7:0] b, input logic eop);
		int k;
		if (!quiet && tx_choppy && $urandom_range(0, 5) == 0) begin
			k = $urandom_range(1, 3);
			repeat (k) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= b;
		s_tlast  <= eop;
		do @(posedge clk); while (!s_tready);
		checksum_step(act, b, eop);
		beats_sent++;
	endtask

	task automatic send_finish();
		send_beat(pcr_pkg::ACT_FINISH, 8'($urandom), 1'($urandom));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (out_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_len(input logic [24:0] v);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		buf_len = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// header fields big-endian, 5,5,1,1,3,2,3 bytes, then the checksum
	task automatic send_packet(input fill_e fill, input csum_e cs, input logic [23:0] frag,
			input logic [23:0] tlen, input int nbytes, input bit cut);
		logic [39:0]  f0, f1;
		logic [7:0]   f2, f3;
		logic [23:0]  f4, f6;
		logic [15:0]  f5;
		logic [42:0]  total;
		logic [31:0]  csum;
		logic [191:0] hdr_bits;
		logic [7:0]   b;
		int           i;
		f0 = {8'($urandom), 32'($urandom)};
		f1 = {8'($urandom), 32'($urandom)};
		f2 = 8'($urandom);
		f3 = 8'($urandom);
		f5 = 16'($urandom);
		f4 = frag;
		f6 = tlen;
		if (fill == FILL_ZERO) begin
			f0 = '0; f1 = '0; f2 = '0; f3 = '0; f5 = '0;
		end else if (fill == FILL_ONES) begin
			f0 = '1; f1 = '1; f2 = '1; f3 = '1; f4 = '1; f5 = '1; f6 = '1;
		end
		total = {3'b0, f0} + {3'b0, f1} + {35'b0, f2} + {35'b0, f3} + {19'b0, f4} +
			{27'b0, f5} + {19'b0, f6};
		csum = 32'(total % FOLD_MOD);
		if (cs == SUM_BAD)
			csum = csum ^ ($urandom | 32'd1);
		else if (cs == SUM_ONES)
			csum = 32'hFFFFFFFF;
		hdr_bits = {f0, f1, f2, f3, f4, f5, f6, csum};
		for (i = 0; i < nbytes; i++) begin
			b = (i < 24) ? hdr_bits[191 - 8 * i -: 8] : 8'($urandom);
			send_beat(pcr_pkg::ACT_BYTE, b, !cut && i == nbytes - 1);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk) begin : result_check
		pcr_pkg::result_t got;
		pcr_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = mk_result(m_tuser, m_tdata[23:0], m_tdata[31:24], m_tdata[32],
				m_tdata[64:33]);
			got.last = m_tlast;
			if (out_due.size() == 0) begin
				$display("%0t: result with nothing due, expected none actual kind %0d tdata %0h",
					$time, m_tuser, m_tdata);
				errs++;
			end else begin
				want = out_due.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("write_index", want.write_index, got.write_index);
				check_field("write_data", want.write_data, got.write_data);
				check_field("accepted", want.accepted, got.accepted);
				check_field("accepted_count", want.accepted_count, got.accepted_count);
				check_field("last", want.last, got.last);
			end
		end
	end

	// receiver backpressure in bursts, with calm stretches in between
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_choppy = $urandom_range(0, 1);
			rx_span   = $urandom_range(20, 200);
		end else begin
			rx_span--;
		end
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else if (!quiet && rx_choppy && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rx_hold = $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		#5ms;
		$display("tb: done, errors");
		$finish;
	end

	initial begin : stim
		plan_row_t        p;
		pcr_pkg::result_t r;
		int               rand_start;
		int               set_size;
		int               pkts_in_set;
		int               lim;
		bit               drained_once;
		fill_e            fl;
		csum_e            cs;
		logic [23:0]      frag;
		logic [23:0]      tlen;
		int               nbytes;
		bit               cut;
		logic [24:0]      v;

		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = pcr_pkg::ACT_BYTE;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		errs      = 0;
		beats_sent = 0;
		quiet     = 1'b0;
		tx_choppy = 1'b1;
		rx_hold   = 0;
		rx_span   = 0;
		rx_choppy = 1'b1;
		buf_len   = pcr_pkg::MSG_LEN_RST;
		good_pkts = '0;
		wr_ptr    = '0;
		max_idx   = '0;
		clear_pkt();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: one row per packet, finish or buffer size change
		plan.push_back(mk_row(ST_FINISH, FILL_RANDOM, SUM_GOOD, 0, 0, 0, 0, 0, -1, 0));
		plan.push_back(mk_row(ST_PACKET, FILL_ZERO, SUM_GOOD, 0, 0, 24, 0, 0, 1, 1));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_GOOD, 0, 30, 1, 0, 0, 0, 1));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_GOOD, 0, 30, 23, 0, 0, 0, 1));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_GOOD, 0, 25, 25, 0, 0, 1, 2));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_BAD, 3, 30, 30, 0, 0, 0, 2));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_ONES, 0, 28, 28, 0, 0, 0, 2));
		plan.push_back(mk_row(ST_PACKET, FILL_ONES, SUM_GOOD, 0, 0, 30, 0, 0, 0, 2));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_GOOD, 5, 32, 40, 0, 0, -1, -1));
		plan.push_back(mk_row(ST_FINISH, FILL_RANDOM, SUM_GOOD, 0, 0, 0, 0, 0, -1, 3));
		plan.push_back(mk_row(ST_CONFIG, FILL_RANDOM, SUM_GOOD, 0, 0, 0, 0, 25'd2, -1, -1));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_GOOD, 1, 30, 30, 0, 0, 0, 0));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_GOOD, 0, 30, 30, 0, 0, 1, 1));
		plan.push_back(mk_row(ST_FINISH, FILL_RANDOM, SUM_GOOD, 0, 0, 0, 0, 0, -1, 1));
		plan.push_back(mk_row(ST_CONFIG, FILL_RANDOM, SUM_GOOD, 0, 0, 0, 0, IDX_SPAN, -1, -1));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_GOOD, 24'hFFFFFE, 30, 30, 0, 0,
			1, 1));
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_GOOD, 24'hFFFFFF, 30, 30, 0, 0,
			0, 1));
		// finish lands mid-packet, after the count was taken
		plan.push_back(mk_row(ST_PACKET, FILL_RANDOM, SUM_GOOD, 2, 40, 26, 1, 0, -1, -1));
		plan.push_back(mk_row(ST_FINISH, FILL_RANDOM, SUM_GOOD, 0, 0, 0, 0, 0, -1, 2));
		plan.push_back(mk_row(ST_FINISH, FILL_RANDOM, SUM_GOOD, 0, 0, 0, 0, 0, -1, 0));

		foreach (plan[i]) begin
			p = plan[i];
			tx_choppy = $urandom_range(0, 2) != 0;
			case (p.step)
				ST_CONFIG: write_len(p.len_val);
				ST_FINISH: send_finish();
				default:   send_packet(p.fill, p.csum, p.frag, p.tlen, p.nbytes, p.cut);
			endcase
			if ((p.want_acc >= 0 || p.want_cnt >= 0) && out_due.size() != 0) begin
				r = out_due.pop_back();
				if (p.want_acc >= 0)
					r.accepted = p.want_acc[0];
				if (p.want_cnt >= 0)
					r.accepted_count = p.want_cnt[31:0];
				out_due.push_back(r);
			end
		end

		write_len(25'($urandom_range(2, 64)));

		rand_start   = beats_sent;
		set_size     = $urandom_range(1, 10);
		pkts_in_set  = 0;
		drained_once = 1'b0;
		while (beats_sent - rand_start < RAND_BEATS) begin
			quiet = (beats_sent - rand_start) > QUIET_AFTER;
			if (!drained_once && beats_sent - rand_start > RAND_BEATS / 2) begin
				wait_drained();
				drained_once = 1'b1;
			end
			if (pkts_in_set >= set_size) begin
				send_finish();
				if ($urandom_range(0, 2) == 0) begin
					case ($urandom_range(0, 3))
						0:       v = 25'd2;
						1:       v = IDX_SPAN;
						2:       v = 25'($urandom_range(2, 64));
						default: v = 25'($urandom_range(2, 32'h1000000));
					endcase
					write_len(v);
				end
				set_size    = $urandom_range(1, 10);
				pkts_in_set = 0;
			end else begin
				tx_choppy = $urandom_range(0, 2) != 0;
				fl = FILL_RANDOM;
				cs = SUM_GOOD;
				case ($urandom_range(0, 19))
					0, 1:    cs = SUM_BAD;
					2:       cs = SUM_ONES;
					3:       fl = FILL_ZERO;
					default: ;
				endcase
				lim = int'(buf_len) - 2;
				case ($urandom_range(0, 9))
					0:       frag = 24'($urandom);
					1, 2:    frag = 24'((lim > 30) ? lim - $urandom_range(0, 30) :
						$urandom_range(0, lim));
					default: frag = 24'($urandom_range(0, (lim > 64) ? 64 : lim));
				endcase
				case ($urandom_range(0, 19))
					0:       tlen = 24'($urandom_range(0, 23));
					1:       tlen = 24'($urandom);
					default: tlen = 24'(24 + $urandom_range(0, 16));
				endcase
				if ($urandom_range(0, 14) == 0)
					nbytes = $urandom_range(1, 23);
				else if (tlen < 24 || tlen > 60)
					nbytes = $urandom_range(24, 48);
				else
					nbytes = $urandom_range(24, int'(tlen) + 4);
				cut = $urandom_range(0, 24) == 0;
				send_packet(fl, cs, frag, tlen, nbytes, cut);
				pkts_in_set++;
				// a cut packet is closed by the finish beat that follows
				if (cut)
					pkts_in_set = set_size;
			end
		end
		send_finish();

		wait_drained();
		repeat (10) @(posedge clk);
		if (errs == 0 && out_due.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
